/* hw/rtl/xep_pkg.sv */
// ---------------------------------------------------------------------------
// xep_pkg: shared types, constants and functions
// Types, store geometry and the rebuild plan for the XOR erasure decoder.
// ---------------------------------------------------------------------------
package xep_pkg;

	localparam int MAX_BLOCK_BYTES = 16;
	localparam int NUM_BLOCKS      = 4;
	localparam int IDX_W           = $clog2(MAX_BLOCK_BYTES);
	localparam int PKT_W           = $clog2(NUM_BLOCKS);
	localparam int ADDR_W          = PKT_W + IDX_W;
	localparam int LEN_W           = 5;
	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

	typedef struct packed {
		logic               we_data;
		logic               we_par;
		logic [ADDR_W-1:0]  addr;
		logic [7:0]         data;
	} st_wr_t;

	typedef struct packed {
		logic             go;
		logic             err;
		logic [PKT_W-1:0] pa;
		logic [PKT_W-1:0] pb;
	} launch_t;

	// One output block = data row src XOR optional parity rows of pa and pb
	typedef struct packed {
		logic [PKT_W-1:0] src;
		logic             use_pa;
		logic             use_pb;
	} plan_t;

	typedef plan_t [NUM_BLOCKS-1:0] plan_set_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RD0,
		SQ_RD1,
		SQ_EMIT
	} sq_state_t;

	// parity of packet k covers blocks k+2 and k+3 (mod 4)
	function automatic logic [PKT_W-1:0] pair_a(input logic [PKT_W-1:0] k);
		return k + PKT_W'(2);
	endfunction

	function automatic logic [PKT_W-1:0] pair_b(input logic [PKT_W-1:0] k);
		return k + PKT_W'(3);
	endfunction

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		if (len == '0)
			return LEN_W'(1);
		else if (len > LEN_W'(MAX_BLOCK_BYTES))
			return LEN_W'(MAX_BLOCK_BYTES);
		else
			return len;
	endfunction

	// symbolic rebuild: two passes over the two received packets
	function automatic plan_set_t rebuild_plan(input logic [PKT_W-1:0] pa,
	                                           input logic [PKT_W-1:0] pb);
		plan_set_t               p;
		logic [NUM_BLOCKS-1:0]   known;
		logic [PKT_W-1:0]        pk;
		logic [PKT_W-1:0]        x;
		logic [PKT_W-1:0]        y;
		logic [PKT_W-1:0]        s;
		logic [PKT_W-1:0]        d;
		logic                    hit;
		p = '0;
		known = '0;
		p[pa].src = pa;
		known[pa] = 1'b1;
		p[pb].src = pb;
		known[pb] = 1'b1;
		for (int pass = 0; pass < 2; pass++) begin
			for (int n = 0; n < 2; n++) begin
				pk  = (n == 0) ? pa : pb;
				x   = pair_a(pk);
				y   = pair_b(pk);
				hit = 1'b0;
				s   = x;
				d   = y;
				if (known[x] && !known[y]) begin
					hit = 1'b1;
				end else if (known[y] && !known[x]) begin
					hit = 1'b1;
					s   = y;
					d   = x;
				end
				if (hit) begin
					p[d] = p[s];
					if (n == 0)
						p[d].use_pa = ~p[s].use_pa;
					else
						p[d].use_pb = ~p[s].use_pb;
					known[d] = 1'b1;
				end
			end
		end
		return p;
	endfunction

endpackage

/* hw/rtl/xep_store.sv */
// ---------------------------------------------------------------------------
// xep_store: data block and parity byte stores
// Two 64x8 memories, one write port each, registered read.
// ---------------------------------------------------------------------------
module xep_store import xep_pkg::*; (
	input  logic              clk,
	input  st_wr_t            wr,
	input  logic [ADDR_W-1:0] d_raddr,
	input  logic [ADDR_W-1:0] p_raddr,
	output logic [7:0]        d_rdata,
	output logic [7:0]        p_rdata
);

	localparam int DEPTH = NUM_BLOCKS * MAX_BLOCK_BYTES;

	logic [7:0] data_mem [DEPTH];
	logic [7:0] par_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we_data)
			data_mem[wr.addr] <= wr.data;
		d_rdata <= data_mem[d_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.we_par)
			par_mem[wr.addr] <= wr.data;
		p_rdata <= par_mem[p_raddr];
	end

endmodule

/* hw/rtl/xep_intake.sv */
// ---------------------------------------------------------------------------
// xep_intake: byte intake and frame tracking
// Routes bytes to the stores and detects the second completed packet.
// ---------------------------------------------------------------------------
module xep_intake import xep_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [LEN_W-1:0] len,
	input  logic             frame_start,
	input  logic [PKT_W-1:0] pkt_index,
	input  logic [4:0]       byte_pos,
	input  logic [7:0]       byte_value,
	output st_wr_t           wr,
	output launch_t          launch
);

	logic             got_first_q;
	logic             frame_done_q;
	logic [PKT_W-1:0] first_q;

	logic             done_eff;
	logic             got_eff;
	logic [5:0]       two_l;
	logic             act;
	logic             is_par;
	logic [4:0]       data_off;
	logic [IDX_W-1:0] idx;
	logic             complete;

	always_comb begin
		done_eff = frame_start ? 1'b0 : frame_done_q;
		got_eff  = frame_start ? 1'b0 : got_first_q;
		two_l    = {len, 1'b0};
		act      = take && !done_eff && ({1'b0, byte_pos} < two_l);
		is_par   = byte_pos < len;
		data_off = byte_pos - len;
		idx      = is_par ? byte_pos[IDX_W-1:0] : data_off[IDX_W-1:0];
		complete = act && ({1'b0, byte_pos} == two_l - 6'd1);

		wr.we_par  = act && is_par;
		wr.we_data = act && !is_par;
		wr.addr    = {pkt_index, idx};
		wr.data    = byte_value;

		launch.go  = complete && got_eff;
		launch.err = pkt_index == first_q;
		launch.pa  = first_q;
		launch.pb  = pkt_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_first_q  <= 1'b0;
			frame_done_q <= 1'b0;
			first_q      <= '0;
		end else if (take) begin
			frame_done_q <= done_eff || (complete && got_eff);
			got_first_q  <= got_eff || complete;
			if (complete && !got_eff)
				first_q <= pkt_index;
		end
	end

endmodule

/* hw/rtl/xep_seq.sv */
// ---------------------------------------------------------------------------
// xep_seq: rebuild sequencer
// Steps through all output bytes, XOR-accumulating store reads.
// ---------------------------------------------------------------------------
module xep_seq import xep_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  launch_t           launch,
	input  logic [LEN_W-1:0]  len,
	input  logic [7:0]        d_rdata,
	input  logic [7:0]        p_rdata,
	output logic [ADDR_W-1:0] d_raddr,
	output logic [ADDR_W-1:0] p_raddr,
	output logic              busy,
	output logic              out_strobe,
	output logic [7:0]        out_byte,
	output logic [5:0]        out_pos,
	output logic              out_last,
	output logic              status
);

	sq_state_t        state_q;
	sq_state_t        state_d;
	plan_set_t        plan_q;
	logic [PKT_W-1:0] pa_q;
	logic [PKT_W-1:0] pb_q;
	logic [PKT_W-1:0] blk_q;
	logic [IDX_W-1:0] byte_q;
	logic [5:0]       k_q;
	logic [7:0]       acc_q;
	logic             strobe_q;
	logic [7:0]       byte_out_q;
	logic [5:0]       pos_q;
	logic             last_q;
	logic             status_q;

	logic             blk_end;
	logic             burst_end;
	logic [LEN_W-1:0] len_m1;

	assign len_m1    = len - LEN_W'(1);
	assign blk_end   = byte_q == len_m1[IDX_W-1:0];
	assign burst_end = blk_end && (blk_q == PKT_W'(NUM_BLOCKS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SQ_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		d_raddr = {plan_q[blk_q].src, byte_q};
		p_raddr = {pa_q, byte_q};
		unique case (state_q)
			SQ_IDLE: begin
				if (launch.go && !launch.err)
					state_d = SQ_RD0;
			end
			SQ_RD0: begin
				state_d = SQ_RD1;
			end
			SQ_RD1: begin
				p_raddr = {pb_q, byte_q};
				state_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				state_d = burst_end ? SQ_IDLE : SQ_RD0;
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	assign busy = state_q != SQ_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= (state_q == SQ_EMIT) || (state_q == SQ_IDLE && launch.go && launch.err);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				if (launch.go) begin
					plan_q     <= rebuild_plan(launch.pa, launch.pb);
					pa_q       <= launch.pa;
					pb_q       <= launch.pb;
					blk_q      <= '0;
					byte_q     <= '0;
					k_q        <= '0;
					byte_out_q <= '0;
					pos_q      <= '0;
					last_q     <= 1'b1;
					status_q   <= 1'b1;
				end
			end
			SQ_RD1: begin
				acc_q <= d_rdata ^ (plan_q[blk_q].use_pa ? p_rdata : 8'h00);
			end
			SQ_EMIT: begin
				byte_out_q <= acc_q ^ (plan_q[blk_q].use_pb ? p_rdata : 8'h00);
				pos_q      <= k_q;
				last_q     <= burst_end;
				status_q   <= 1'b0;
				k_q        <= k_q + 6'd1;
				if (blk_end) begin
					byte_q <= '0;
					blk_q  <= blk_q + PKT_W'(1);
				end else begin
					byte_q <= byte_q + IDX_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_strobe = strobe_q;
	assign out_byte   = byte_out_q;
	assign out_pos    = pos_q;
	assign out_last   = last_q;
	assign status     = status_q;

endmodule

/* hw/rtl/xor_erasure_packet_decoder.sv */
// ---------------------------------------------------------------------------
// xor_erasure_packet_decoder: XOR parity erasure decoder, four data blocks
// Recovers a packet of 4*L bytes from any two distinct encoded packets.
// ---------------------------------------------------------------------------
// A byte request is taken on a clock edge with start high and busy low; while
// idle the block takes one byte per cycle. Parity bytes (position below L) and
// data bytes (L..2L-1) are written into two 64x8 stores addressed by packet
// index and byte offset. A packet completes on its byte at position 2L-1.
// When a second packet with another index completes, busy rises for the
// rebuild burst: a small sequencer walks the 4L output bytes, and for each
// one issues a data-store and parity-store read, then a second parity read,
// XOR-accumulating through one shared datapath; busy stays high through the
// burst. Results appear the cycle after each sequencer emit, on out_strobe
// for exactly one cycle; the receiver cannot stall, so it must take every
// strobe. The final byte carries out_last. A second completion of the same
// index instead gives a single error result (status 1, out_last 1, zero byte
// and position) with no busy period. After either, bytes are dropped until
// a request with frame_start. block_len is written by cfg_we/cfg_data; the
// user must write it only while idle, the block itself does not enforce
// this. 0 acts as 1 and values above 16 act as 16. Stores have no reset: a
// rebuild that reads bytes never received returns unspecified values.
// ---------------------------------------------------------------------------
module xor_erasure_packet_decoder import xep_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             frame_start,
	input  logic [PKT_W-1:0] pkt_index,
	input  logic [4:0]       byte_pos,
	input  logic [7:0]       byte_value,
	output logic             out_strobe,
	output logic [7:0]       out_byte,
	output logic [5:0]       out_pos,
	output logic             out_last,
	output logic             status
);

	logic [LEN_W-1:0]  block_len_q;
	logic [LEN_W-1:0]  len;
	logic              take;
	st_wr_t            wr;
	launch_t           launch;
	logic [ADDR_W-1:0] d_raddr;
	logic [ADDR_W-1:0] p_raddr;
	logic [7:0]        d_rdata;
	logic [7:0]        p_rdata;

	// configuration register, clamped on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			block_len_q <= LEN_RESET;
		else if (cfg_we)
			block_len_q <= cfg_data;
	end

	assign len  = eff_len(block_len_q);
	assign take = start && !busy;

	xep_intake u_intake (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.len         (len),
		.frame_start (frame_start),
		.pkt_index   (pkt_index),
		.byte_pos    (byte_pos),
		.byte_value  (byte_value),
		.wr          (wr),
		.launch      (launch)
	);

	xep_store u_store (
		.clk     (clk),
		.wr      (wr),
		.d_raddr (d_raddr),
		.p_raddr (p_raddr),
		.d_rdata (d_rdata),
		.p_rdata (p_rdata)
	);

	// shared read/XOR sequencer
	xep_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.launch     (launch),
		.len        (len),
		.d_rdata    (d_rdata),
		.p_rdata    (p_rdata),
		.d_raddr    (d_raddr),
		.p_raddr    (p_raddr),
		.busy       (busy),
		.out_strobe (out_strobe),
		.out_byte   (out_byte),
		.out_pos    (out_pos),
		.out_last   (out_last),
		.status     (status)
	);

	// error result is a lone zero record
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && status |-> out_last && out_byte == 8'h00 && out_pos == 6'd0)
		else $error("error result malformed");

	// the sequencer is back to idle when the last byte is shown
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && out_last |-> !busy)
		else $error("busy after last result");

	// mid-burst results only while the sequencer runs
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && !out_last |-> busy)
		else $error("result outside burst");

	// positions climb by one within a burst
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_strobe && !status && out_pos != 6'd0 |->
			out_pos == $past(out_pos, 3) + 6'd1)
		else $error("position skipped");

endmodule

/* test/xep_recovery_checker.sv */
// ---------------------------------------------------------------------------
// xep_recovery_checker: prediction and comparison for the XOR erasure decoder
// Tracks accepted byte requests and block_len writes, predicts the recovered
// bytes or the repeated-index error, and checks each strobed result in order.
// ---------------------------------------------------------------------------
module xep_recovery_checker import xep_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             frame_start,
	input  logic [PKT_W-1:0] pkt_index,
	input  logic [4:0]       byte_pos,
	input  logic [7:0]       byte_value,
	input  logic             out_strobe,
	input  logic [7:0]       out_byte,
	input  logic [5:0]       out_pos,
	input  logic             out_last,
	input  logic             status,
	output int               errors,
	output int               pending
);

	typedef struct packed {
		logic [7:0] val;
		logic [5:0] pos;
		logic       last;
		logic       dup;
	} recov_t;

	localparam int RING_DEPTH = 128;

	recov_t           expected_ring [RING_DEPTH];
	int               ring_head = 0;
	int               ring_tail = 0;
	logic [7:0]       data_mem [NUM_BLOCKS*MAX_BLOCK_BYTES];
	logic [7:0]       par_mem  [NUM_BLOCKS*MAX_BLOCK_BYTES];
	logic [LEN_W-1:0] len_reg;
	int               done_pkts;
	logic [PKT_W-1:0] first_pkt;
	logic             frame_closed;
	int               err_cnt = 0;

	// append one predicted result in arrival order
	function automatic void stash_result(input recov_t e);
		expected_ring[ring_tail % RING_DEPTH] = e;
		ring_tail++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int                    len;
		int                    pos;
		int                    pkt;
		int                    k;
		int                    x;
		int                    y;
		int                    s;
		int                    d;
		int                    b;
		int                    j;
		int                    n;
		int                    sweep;
		logic [NUM_BLOCKS-1:0] known;
		logic [7:0]            blk [NUM_BLOCKS][MAX_BLOCK_BYTES];
		recov_t                r;
		if (!arst_n) begin
			len_reg = LEN_RESET;
			done_pkts = 0;
			first_pkt = '0;
			frame_closed = 1'b0;
			for (j = 0; j < NUM_BLOCKS*MAX_BLOCK_BYTES; j++) begin
				data_mem[j] = 8'h00;
				par_mem[j] = 8'h00;
			end
			ring_head = 0;
			ring_tail = 0;
			pending <= 0;
			errors <= err_cnt;
		end else begin
			if (out_strobe) begin
				if (ring_tail == ring_head) begin
					$error("unexpected result: out_pos %0d out_byte %02h", out_pos, out_byte);
					err_cnt++;
				end else begin
					r = expected_ring[ring_head % RING_DEPTH];
					ring_head++;
					if (out_byte !== r.val) begin
						$error("out_byte: expected %02h, got %02h", r.val, out_byte);
						err_cnt++;
					end
					if (out_pos !== r.pos) begin
						$error("out_pos: expected %0d, got %0d", r.pos, out_pos);
						err_cnt++;
					end
					if (out_last !== r.last) begin
						$error("out_last: expected %0b, got %0b", r.last, out_last);
						err_cnt++;
					end
					if (status !== r.dup) begin
						$error("status: expected %0b, got %0b", r.dup, status);
						err_cnt++;
					end
				end
			end

			if (start && !busy) begin
				// 0 behaves as 1, anything past the store depth as the depth
				if (len_reg == '0)
					len = 1;
				else if (int'(len_reg) > MAX_BLOCK_BYTES)
					len = MAX_BLOCK_BYTES;
				else
					len = int'(len_reg);
				pos = int'(byte_pos);
				pkt = int'(pkt_index);
				if (frame_start) begin
					done_pkts = 0;
					frame_closed = 1'b0;
				end
				if (!frame_closed && pos < 2*len) begin
					if (pos < len)
						par_mem[pkt*MAX_BLOCK_BYTES + pos] = byte_value;
					else
						data_mem[pkt*MAX_BLOCK_BYTES + pos - len] = byte_value;
					if (pos == 2*len - 1) begin
						if (done_pkts == 0) begin
							first_pkt = pkt_index;
							done_pkts = 1;
						end else begin
							frame_closed = 1'b1;
							if (pkt_index == first_pkt) begin
								r = '{val: 8'h00, pos: 6'd0, last: 1'b1, dup: 1'b1};
								stash_result(r);
							end else begin
								known = '0;
								for (b = 0; b < NUM_BLOCKS; b++)
									for (j = 0; j < MAX_BLOCK_BYTES; j++)
										blk[b][j] = 8'h00;
								// packet k carries data block k
								for (n = 0; n < 2; n++) begin
									k = (n == 0) ? int'(first_pkt) : pkt;
									for (j = 0; j < len; j++)
										blk[k][j] = data_mem[k*MAX_BLOCK_BYTES + j];
									known[k] = 1'b1;
								end
								// parity of k covers blocks k+2, k+3; peel one unknown per hit
								for (sweep = 0; sweep < 2; sweep++) begin
									for (n = 0; n < 2; n++) begin
										k = (n == 0) ? int'(first_pkt) : pkt;
										x = (k + 2) % NUM_BLOCKS;
										y = (k + 3) % NUM_BLOCKS;
										if (known[x] != known[y]) begin
											s = known[x] ? x : y;
											d = known[x] ? y : x;
											for (j = 0; j < len; j++)
												blk[d][j] = par_mem[k*MAX_BLOCK_BYTES + j] ^ blk[s][j];
											known[d] = 1'b1;
										end
									end
								end
								for (b = 0; b < NUM_BLOCKS; b++) begin
									for (j = 0; j < len; j++) begin
										r.val = blk[b][j];
										r.pos = 6'(b*len + j);
										r.last = (b == NUM_BLOCKS-1) && (j == len-1);
										r.dup = 1'b0;
										stash_result(r);
									end
								end
							end
						end
					end
				end
			end

			// a write lands after any request taken on the same edge
			if (cfg_we)
				len_reg = cfg_data;

			pending <= ring_tail - ring_head;
			errors <= err_cnt;
		end
	end

endmodule

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the XOR erasure packet decoder
// Drives byte requests and block_len writes with random gaps; a checker
// beside the block predicts every recovered byte and error result.
// ---------------------------------------------------------------------------
module tb_top import xep_pkg::*; ();

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic             cfg_we      = 1'b0;
	logic [LEN_W-1:0] cfg_data    = '0;
	logic             frame_start = 1'b0;
	logic [PKT_W-1:0] pkt_index   = '0;
	logic [4:0]       byte_pos    = '0;
	logic [7:0]       byte_value  = '0;
	logic             busy;
	logic             out_strobe;
	logic [7:0]       out_byte;
	logic [5:0]       out_pos;
	logic             out_last;
	logic             status;
	int               errors;
	int               pending;

	// sender-side view of the frame, used only to keep stimulus legal:
	// a rebuild must never read a store entry that was never written
	int  cur_len = 3;                 // effective L as the block sees it
	int  open_pkts = 0;               // completions in the current frame
	bit  sealed = 1'b0;               // frame done, bytes dropped
	bit  par_wr [NUM_BLOCKS*MAX_BLOCK_BYTES];
	bit  dat_wr [NUM_BLOCKS*MAX_BLOCK_BYTES];
	int  live_items = 0;              // requests taken so far
	bit  steady = 1'b0;               // back-to-back stretch, no gaps

	always #5 clk = ~clk;

	xor_erasure_packet_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.frame_start(frame_start),
		.pkt_index  (pkt_index),
		.byte_pos   (byte_pos),
		.byte_value (byte_value),
		.out_strobe (out_strobe),
		.out_byte   (out_byte),
		.out_pos    (out_pos),
		.out_last   (out_last),
		.status     (status)
	);

	xep_recovery_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.frame_start(frame_start),
		.pkt_index  (pkt_index),
		.byte_pos   (byte_pos),
		.byte_value (byte_value),
		.out_strobe (out_strobe),
		.out_byte   (out_byte),
		.out_pos    (out_pos),
		.out_last   (out_last),
		.status     (status),
		.errors     (errors),
		.pending    (pending)
	);

	// hard stop, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("Verification failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	task automatic idle_gap();
		int r;
		int g;
		r = $urandom_range(0, 99);
		g = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 40);
		if (!steady && g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// one byte request; returns on the edge that takes it, then maybe idles
	task automatic send_byte(input bit fs, input int pkt, input int pos, input logic [7:0] v);
		start       <= 1'b1;
		frame_start <= fs;
		pkt_index   <= PKT_W'(pkt);
		byte_pos    <= 5'(pos);
		byte_value  <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		live_items++;
		if (fs) begin
			open_pkts = 0;
			sealed = 1'b0;
		end
		if (!sealed && pos < 2*cur_len) begin
			if (pos < cur_len)
				par_wr[pkt*MAX_BLOCK_BYTES + pos] = 1'b1;
			else
				dat_wr[pkt*MAX_BLOCK_BYTES + pos - cur_len] = 1'b1;
			if (pos == 2*cur_len - 1) begin
				if (open_pkts == 0)
					open_pkts = 1;
				else
					sealed = 1'b1;
			end
		end
		idle_gap();
	endtask

	// hold requests off until every predicted result has come out;
	// the first edge lets a push from the last accepted request land
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// block_len is only written with the block idle
	task automatic set_block_len(input int v);
		drain();
		repeat (10) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= LEN_W'(v);
		@(posedge clk);
		cfg_we   <= 1'b0;
		cur_len = (v == 0) ? 1 : (v > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : v;
	endtask

	// one encoded packet in shuffled order, completing byte last.
	// lossy: may drop bytes whose store entry already holds something.
	// noisy: may slip in out-of-range bytes or non-completing stray writes.
	// fill < 0 gives random bytes, otherwise every byte is fill.
	task automatic send_packet(input bit fs, input int pkt, input bit lossy, input bit noisy,
	                           input int fill);
		int order [32];
		int n;
		int i;
		int j;
		int t;
		int p;
		bit fs_due;
		bit seen;
		n = 2*cur_len;
		for (i = 0; i < n-1; i++)
			order[i] = i;
		for (i = n-2; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		order[n-1] = n-1;
		fs_due = fs;
		for (i = 0; i < n; i++) begin
			p = order[i];
			seen = (p < cur_len) ? par_wr[pkt*MAX_BLOCK_BYTES + p]
			                     : dat_wr[pkt*MAX_BLOCK_BYTES + p - cur_len];
			if (!(lossy && p != n-1 && seen && $urandom_range(0, 2) == 0)) begin
				send_byte(fs_due, pkt, p, (fill < 0) ? 8'($urandom) : 8'(fill));
				fs_due = 1'b0;
				if (noisy && i < n-1 && $urandom_range(0, 7) == 0) begin
					if (n <= 31 && $urandom_range(0, 1) == 1)
						send_byte(1'b0, $urandom_range(0, 3), $urandom_range(n, 31), 8'($urandom));
					else
						send_byte(1'b0, $urandom_range(0, 3), $urandom_range(0, n-2), 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		int r;
		int a;
		int b;
		int len_pick;
		int phase;
		int frames_left;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset length (3): all-ones packet 0 with all-zeros packet 2
		send_packet(1'b1, 0, 1'b0, 1'b0, 8'hFF);
		send_packet(1'b0, 2, 1'b0, 1'b0, 8'h00);
		// frame done: dropped, even a completing position
		send_byte(1'b0, 1, 5, 8'h3C);
		send_byte(1'b0, 3, 31, 8'hC3);

		// shortest blocks; position past the packet is dropped mid-frame
		set_block_len(1);
		send_byte(1'b1, 3, 0, 8'h81);
		send_byte(1'b0, 3, 31, 8'h7E);
		send_byte(1'b0, 3, 1, 8'h42);
		send_byte(1'b0, 1, 0, 8'($urandom));
		send_byte(1'b0, 1, 1, 8'($urandom));

		// same index completes twice: single error request result
		send_byte(1'b1, 2, 0, 8'($urandom));
		send_byte(1'b0, 2, 1, 8'($urandom));
		send_byte(1'b0, 2, 1, 8'($urandom));

		// length shrinks between the two completions of one frame
		set_block_len(2);
		send_packet(1'b1, 1, 1'b0, 1'b0, -1);
		set_block_len(1);
		send_byte(1'b0, 0, 0, 8'($urandom));
		send_byte(1'b0, 0, 1, 8'($urandom));

		// --- random frames ---
		// phases of a few frames per length; the first two hit 0 and 31
		phase = 0;
		frames_left = 0;
		while (live_items < 210) begin
			if (frames_left == 0) begin
				r = $urandom_range(0, 99);
				if (phase == 0)
					len_pick = 0;
				else if (phase == 1)
					len_pick = 31;
				else if (r < 10)
					len_pick = 0;
				else if (r < 55)
					len_pick = $urandom_range(1, 3);
				else if (r < 80)
					len_pick = $urandom_range(4, 8);
				else if (r < 88)
					len_pick = $urandom_range(9, 15);
				else if (r < 93)
					len_pick = MAX_BLOCK_BYTES;
				else
					len_pick = $urandom_range(17, 31);
				set_block_len(len_pick);
				frames_left = (cur_len > 8) ? 1 : $urandom_range(2, 4);
				phase++;
			end
			frames_left--;
			steady = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			a = $urandom_range(0, 3);
			if (r >= 85) begin
				// abandoned frame: one packet, scattered positions, then a new frame
				send_byte(1'b1, a, $urandom_range(0, 2*cur_len-1), 8'($urandom));
				repeat ($urandom_range(0, 2*cur_len-1))
					send_byte(1'b0, a, $urandom_range(0, 2*cur_len-1), 8'($urandom));
			end else begin
				send_packet(1'b1, a, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0, -1);
				if (r < 65) begin
					// well-formed: a second, distinct packet triggers the rebuild
					b = (a + $urandom_range(1, 3)) % NUM_BLOCKS;
					send_packet(1'b0, b, $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0, -1);
					if ($urandom_range(0, 4) == 0)
						drain();
				end else begin
					// the first packet again, partly resent, then completed
					repeat ($urandom_range(0, 3))
						send_byte(1'b0, a, $urandom_range(0, 2*cur_len-2), 8'($urandom));
					send_byte(1'b0, a, 2*cur_len-1, 8'($urandom));
				end
				// anything after the frame is done must be dropped
				repeat ($urandom_range(0, 3))
					send_byte(1'b0, $urandom_range(0, 3), $urandom_range(0, 31), 8'($urandom));
			end
		end
		steady = 1'b0;

		drain();
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
